// File: hdl/epts_pkg.sv
// shared types and codes for the eeprom paged transfer sequencer
package epts_pkg;

	// default page size of the eeprom in bytes
	localparam int unsigned PAGE_BYTES_DEF = 32;

	// write-cycle wait after reset, in millisecond ticks
	localparam logic [7:0] WRITE_TICKS_RST = 8'd5;
	localparam logic [7:0] WAIT_SAT = 8'hFF;

	// memory address bytes leading every send frame
	localparam logic [15:0] ADDR_BYTES = 16'd2;

	// event kinds
	localparam logic [2:0] FN_WRITE_POLL = 3'd0;
	localparam logic [2:0] FN_READ_POLL = 3'd1;
	localparam logic [2:0] FN_TX_DONE = 3'd2;
	localparam logic [2:0] FN_RX_DONE = 3'd3;
	localparam logic [2:0] FN_ERROR = 3'd4;
	localparam logic [2:0] FN_TICK = 3'd5;
	localparam logic [2:0] FN_STATUS_RESET = 3'd6;

	// bus master commands
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_SEND = 2'd1;
	localparam logic [1:0] CMD_RECV = 2'd2;
	localparam logic [1:0] CMD_STOP = 2'd3;

	// error codes that abort a transfer
	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_BUS_BUSY = 3'd1;
	localparam logic [2:0] ERR_START_FAULT = 3'd2;
	localparam logic [2:0] ERR_STOP_DETECT = 3'd3;
	localparam logic [2:0] ERR_NO_ACK = 3'd4;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  device_address;
		logic [15:0] memory_address;
		logic [15:0] transfer_length;
		logic [2:0]  error_code;
	} req_t;

endpackage

// File: hdl/eeprom_paged_transfer_sequencer_core.sv
// eeprom paged transfer sequencer: event pipeline, page split and transfer control
//
// Takes one event request per cycle while req_ready is high (write poll, read poll, tx done,
// rx done, error, tick, status reset) and returns exactly one result per request, in order:
// the phase after the event, the bus command to issue (send, receive or stop) with its
// device, memory address, buffer offset and byte count, and the last recorded error. A write
// is cut into pages of PAGE_BYTES; each send frame counts the two address bytes. After each
// page stop the block waits write_cycle_ticks millisecond ticks before the next page. The
// sustained rate is one request per cycle while the result side does not stall; each request
// passes an input register, then the two stages that divide the transfer length by the page
// size (reciprocal multiply, then back-multiply and remainder), then the stage that updates
// the transfer state and registers the result. write_cycle_ticks is written through
// cfg_wr_en/cfg_wr_data and resets to 5.
module eeprom_paged_transfer_sequencer_core #(
	parameter int unsigned PAGE_BYTES = epts_pkg::PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  device_address,
	input  logic [15:0] memory_address,
	input  logic [15:0] transfer_length,
	input  logic [2:0]  error_code,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [3:0]  status,
	output logic [1:0]  bus_command,
	output logic [7:0]  bus_device,
	output logic [15:0] frame_address,
	output logic [15:0] buffer_offset,
	output logic [15:0] byte_count,
	output logic [2:0]  recorded_error
);

	localparam logic [3:0] PH_NONE  = 4'd0;
	localparam logic [3:0] PH_IDLE  = 4'd1;
	localparam logic [3:0] PH_PREP  = 4'd2;
	localparam logic [3:0] PH_SEND  = 4'd3;
	localparam logic [3:0] PH_WAIT  = 4'd4;
	localparam logic [3:0] PH_CHECK = 4'd5;
	localparam logic [3:0] PH_DONE  = 4'd6;
	localparam logic [3:0] PH_ASEND = 4'd7;
	localparam logic [3:0] PH_AWAIT = 4'd8;
	localparam logic [3:0] PH_RECV  = 4'd9;
	localparam logic [3:0] PH_RWAIT = 4'd10;

	// remainder before correction stays below twice the page size
	localparam int unsigned RW = $clog2(2 * PAGE_BYTES);
	// page byte count, up to the page size
	localparam int unsigned CW = $clog2(PAGE_BYTES + 1);
	// frame length, page bytes plus the two address bytes
	localparam int unsigned FW = $clog2(PAGE_BYTES + 3);
	localparam int unsigned RECIP_SHIFT = 24;
	localparam logic [24:0] RECIP = 25'((33'd1 << RECIP_SHIFT) / PAGE_BYTES);
	localparam logic [RW-1:0] PAGE_R = RW'(PAGE_BYTES);
	localparam logic [CW-1:0] PAGE_C = CW'(PAGE_BYTES);
	localparam logic [15:0] PAGE_W = 16'(PAGE_BYTES);

	// handshake and stage control
	logic rsp_free, s3_free, s2_free, s1_free, upd;
	logic valid_s1, valid_s2, valid_s3;
	epts_pkg::req_t req_s1, req_s2, req_s3;
	logic [15:0] qest_s2, qest_s3;
	logic [RW-1:0] rraw_s3;
	logic [40:0] recip_prod;
	logic [24:0] back_prod;
	logic [15:0] rdiff;

	// configuration
	logic [7:0] write_cycle_ticks_q;

	// transfer state
	logic [3:0]    phase_q, phase_d;
	logic [7:0]    wait_count_q, wait_count_d;
	logic [7:0]    saved_device_q, saved_device_d;
	logic [15:0]   start_address_q, start_address_d;
	logic [15:0]   saved_length_q, saved_length_d;
	logic [CW-1:0] saved_rem_q, saved_rem_d;
	logic [15:0]   total_pages_q, total_pages_d;
	logic [15:0]   page_index_q, page_index_d;
	logic [15:0]   page_off_q, page_off_d;
	logic [15:0]   bytes_done_q, bytes_done_d;
	logic [15:0]   page_address_q, page_address_d;
	logic [FW-1:0] frame_length_q, frame_length_d;
	logic [2:0]    last_error_q, last_error_d;

	// result register
	logic        rsp_valid_q;
	logic [3:0]  status_q;
	logic [1:0]  bus_command_q, cmd_d;
	logic [7:0]  bus_device_q, dev_d;
	logic [15:0] frame_address_q, faddr_d;
	logic [15:0] buffer_offset_q, boff_d;
	logic [15:0] byte_count_q, bcnt_d;
	logic [2:0]  recorded_error_q;

	// division correction
	logic          rem_over;
	logic [RW-1:0] rem_fix;
	logic [15:0]   quot_fix;
	logic [15:0]   pages_ceil;
	logic [CW-1:0] page_size;

	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign s3_free = !valid_s3 || rsp_free;
	assign s2_free = !valid_s2 || s3_free;
	assign s1_free = !valid_s1 || s2_free;
	assign req_ready = s1_free;
	assign upd = valid_s3 && rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_free) valid_s1 <= req_valid;
			if (s2_free) valid_s2 <= valid_s1;
			if (s3_free) valid_s3 <= valid_s2;
			if (rsp_free) rsp_valid_q <= valid_s3;
		end
	end

	// length divided by page size: estimate is the true quotient or one less
	assign recip_prod = 41'(req_s1.transfer_length) * 41'(RECIP);
	assign back_prod = 25'(qest_s2) * 25'(PAGE_BYTES);
	assign rdiff = req_s2.transfer_length - back_prod[15:0];

	always_ff @(posedge clk) begin
		if (s1_free && req_valid) begin
			req_s1.func <= func;
			req_s1.device_address <= device_address;
			req_s1.memory_address <= memory_address;
			req_s1.transfer_length <= transfer_length;
			req_s1.error_code <= error_code;
		end
		if (s2_free && valid_s1) begin
			req_s2 <= req_s1;
			qest_s2 <= recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
		end
		if (s3_free && valid_s2) begin
			req_s3 <= req_s2;
			qest_s3 <= qest_s2;
			rraw_s3 <= rdiff[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_cycle_ticks_q <= epts_pkg::WRITE_TICKS_RST;
		end else if (cfg_wr_en) begin
			write_cycle_ticks_q <= cfg_wr_data;
		end
	end

	always_comb begin
		rem_over = rraw_s3 >= PAGE_R;
		rem_fix = rem_over ? rraw_s3 - PAGE_R : rraw_s3;
		quot_fix = qest_s3 + {15'd0, rem_over};
		pages_ceil = quot_fix + {15'd0, rem_fix != '0};
		page_size = ((page_index_q == total_pages_q - 16'd1) && (saved_rem_q != '0)) ?
			saved_rem_q : PAGE_C;

		phase_d = phase_q;
		wait_count_d = wait_count_q;
		saved_device_d = saved_device_q;
		start_address_d = start_address_q;
		saved_length_d = saved_length_q;
		saved_rem_d = saved_rem_q;
		total_pages_d = total_pages_q;
		page_index_d = page_index_q;
		page_off_d = page_off_q;
		bytes_done_d = bytes_done_q;
		page_address_d = page_address_q;
		frame_length_d = frame_length_q;
		last_error_d = last_error_q;
		cmd_d = epts_pkg::CMD_NONE;
		dev_d = '0;
		faddr_d = '0;
		boff_d = '0;
		bcnt_d = '0;

		case (req_s3.func)
			epts_pkg::FN_WRITE_POLL: begin
				case (phase_q)
					PH_IDLE: begin
						saved_device_d = req_s3.device_address;
						start_address_d = req_s3.memory_address;
						saved_length_d = req_s3.transfer_length;
						saved_rem_d = CW'(rem_fix);
						wait_count_d = epts_pkg::WAIT_SAT;
						page_index_d = '0;
						page_off_d = '0;
						bytes_done_d = '0;
						total_pages_d = pages_ceil;
						phase_d = PH_PREP;
					end
					PH_PREP: begin
						// a zero-length write never leaves prepare
						if (page_index_q < total_pages_q) begin
							page_address_d = start_address_q + page_off_q;
							bytes_done_d = bytes_done_q + 16'(page_size);
							page_index_d = page_index_q + 16'd1;
							page_off_d = page_off_q + PAGE_W;
							frame_length_d = FW'(page_size) + FW'(epts_pkg::ADDR_BYTES);
							phase_d = PH_SEND;
						end
					end
					PH_SEND: begin
						cmd_d = epts_pkg::CMD_SEND;
						dev_d = saved_device_q;
						faddr_d = page_address_q;
						boff_d = bytes_done_q - 16'(frame_length_q) + epts_pkg::ADDR_BYTES;
						bcnt_d = 16'(frame_length_q);
						phase_d = PH_WAIT;
					end
					PH_CHECK: begin
						if (wait_count_q >= write_cycle_ticks_q) begin
							wait_count_d = '0;
							phase_d = (page_index_q < total_pages_q) ? PH_PREP : PH_DONE;
						end
					end
					PH_DONE: begin
						last_error_d = epts_pkg::ERR_NONE;
					end
					default: begin
					end
				endcase
			end
			epts_pkg::FN_READ_POLL: begin
				case (phase_q)
					PH_IDLE: begin
						saved_device_d = req_s3.device_address;
						start_address_d = req_s3.memory_address;
						saved_length_d = req_s3.transfer_length;
						saved_rem_d = CW'(rem_fix);
						wait_count_d = epts_pkg::WAIT_SAT;
						phase_d = PH_PREP;
					end
					PH_PREP: begin
						phase_d = PH_ASEND;
					end
					PH_ASEND: begin
						cmd_d = epts_pkg::CMD_SEND;
						dev_d = saved_device_q;
						faddr_d = start_address_q;
						bcnt_d = epts_pkg::ADDR_BYTES;
						phase_d = PH_AWAIT;
					end
					PH_RECV: begin
						cmd_d = epts_pkg::CMD_RECV;
						dev_d = saved_device_q;
						bcnt_d = saved_length_q;
						phase_d = PH_RWAIT;
					end
					PH_CHECK: begin
						phase_d = PH_DONE;
					end
					PH_DONE: begin
						last_error_d = epts_pkg::ERR_NONE;
					end
					default: begin
					end
				endcase
			end
			epts_pkg::FN_TX_DONE: begin
				if (phase_q == PH_AWAIT) begin
					phase_d = PH_RECV;
				end else if (phase_q == PH_WAIT) begin
					cmd_d = epts_pkg::CMD_STOP;
					dev_d = saved_device_q;
					wait_count_d = '0;
					phase_d = PH_CHECK;
				end
			end
			epts_pkg::FN_RX_DONE: begin
				if (phase_q == PH_RWAIT) phase_d = PH_CHECK;
			end
			epts_pkg::FN_ERROR: begin
				last_error_d = req_s3.error_code;
				if (req_s3.error_code == epts_pkg::ERR_BUS_BUSY ||
				    req_s3.error_code == epts_pkg::ERR_START_FAULT ||
				    req_s3.error_code == epts_pkg::ERR_STOP_DETECT ||
				    req_s3.error_code == epts_pkg::ERR_NO_ACK) begin
					phase_d = PH_IDLE;
				end
			end
			epts_pkg::FN_TICK: begin
				if (wait_count_q != epts_pkg::WAIT_SAT) wait_count_d = wait_count_q + 8'd1;
			end
			epts_pkg::FN_STATUS_RESET: begin
				phase_d = PH_IDLE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NONE;
			wait_count_q <= epts_pkg::WAIT_SAT;
			saved_device_q <= '0;
			start_address_q <= '0;
			saved_length_q <= '0;
			saved_rem_q <= '0;
			total_pages_q <= '0;
			page_index_q <= '0;
			page_off_q <= '0;
			bytes_done_q <= '0;
			page_address_q <= '0;
			frame_length_q <= '0;
			last_error_q <= '0;
		end else if (upd) begin
			phase_q <= phase_d;
			wait_count_q <= wait_count_d;
			saved_device_q <= saved_device_d;
			start_address_q <= start_address_d;
			saved_length_q <= saved_length_d;
			saved_rem_q <= saved_rem_d;
			total_pages_q <= total_pages_d;
			page_index_q <= page_index_d;
			page_off_q <= page_off_d;
			bytes_done_q <= bytes_done_d;
			page_address_q <= page_address_d;
			frame_length_q <= frame_length_d;
			last_error_q <= last_error_d;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			status_q <= phase_d;
			bus_command_q <= cmd_d;
			bus_device_q <= dev_d;
			frame_address_q <= faddr_d;
			buffer_offset_q <= boff_d;
			byte_count_q <= bcnt_d;
			recorded_error_q <= last_error_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign bus_command = bus_command_q;
	assign bus_device = bus_device_q;
	assign frame_address = frame_address_q;
	assign buffer_offset = buffer_offset_q;
	assign byte_count = byte_count_q;
	assign recorded_error = recorded_error_q;

	// never more pages issued than the write was split into
	assert property (@(posedge clk) disable iff (!arst_n)
		page_index_q <= total_pages_q)
		else $error("page index beyond page total");

	// a stop is only issued on the way into the write-cycle check
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bus_command == epts_pkg::CMD_STOP |-> status == PH_CHECK)
		else $error("stop command outside check phase");

	// a page frame holds at least one data byte and at most one page
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bus_command == epts_pkg::CMD_SEND && status == PH_WAIT |->
		byte_count >= 16'd3 && byte_count <= PAGE_W + epts_pkg::ADDR_BYTES)
		else $error("page frame length out of range");

	// a receive always asks for the saved transfer length
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bus_command == epts_pkg::CMD_RECV |->
		status == PH_RWAIT && byte_count == saved_length_q)
		else $error("receive command inconsistent with saved request");

endmodule
